// ===== sv/modexp_pkg.sv =====
// Shared widths, constants and types of the modular exponentiation block.
package modexp_pkg;

  // Data word width: the message is masked to this many bits and only this
  // many low exponent bits are scanned.
  localparam int WORD_BITS = 64;

  localparam int MSG_W     = 64;  // message field
  localparam int EXP_W     = 64;  // exponent register
  localparam int VAL_W     = 63;  // modulus and every reduced value
  localparam int SUM_W     = VAL_W + 1;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 64;
  localparam int OUT_W     = 64;  // power padded to whole bytes

  localparam logic [MSG_W-1:0] MSG_MASK = {MSG_W{1'b1}} >> (MSG_W - WORD_BITS);
  localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - WORD_BITS);

  localparam logic [VAL_W-1:0] MODULUS_RESET  = VAL_W'(3233);
  localparam logic [EXP_W-1:0] EXPONENT_RESET = EXP_W'(65537);

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_DONE
  } mx_state_t;

endpackage

// ===== sv/modexp_mulmod.sv =====
// Bit-serial modular multiplier: product = a * b mod n, one bit of b per cycle.
module modexp_mulmod import modexp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [MSG_W-1:0] b,
  input  logic [VAL_W-1:0] n,
  output logic             busy,
  output logic [VAL_W-1:0] product
);

  logic             busy_r, busy_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] a_r, a_nxt;
  logic [MSG_W-1:0] b_r, b_nxt;

  logic [SUM_W-1:0] n_ext;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] dbl;
  logic [VAL_W-1:0] acc_step;
  logic [VAL_W-1:0] a_step;
  logic             stepping;

  // Right-to-left shift-and-add: the accumulator and the doubled operand are
  // each brought back below n by one conditional subtraction per cycle.
  always_comb begin
    n_ext    = {1'b0, n};
    sum      = {1'b0, acc_r} + (b_r[0] ? {1'b0, a_r} : '0);
    dbl      = {a_r, 1'b0};
    acc_step = (sum >= n_ext) ? VAL_W'(sum - n_ext) : sum[VAL_W-1:0];
    a_step   = (dbl >= n_ext) ? VAL_W'(dbl - n_ext) : dbl[VAL_W-1:0];
    stepping = busy_r && (b_r != '0);
  end

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
    end else if (stepping) begin
      acc_nxt = acc_step;
      a_nxt   = a_step;
      b_nxt   = b_r >> 1;
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

// ===== sv/modular_exponentiation_top.sv =====
// Top level of the modular exponentiation block: control sequencer and registers.
// It reduces the message, then runs one multiply round per exponent bit up to the highest
// set one and finally loads the output register. A new word is taken only once the
// previous result has reached the output register.
// Reset (rst_n, synchronous, active low) empties the block and the output register and
// sets the modulus to 3233 and the exponent to 65537.
module modular_exponentiation_top import modexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [MSG_W-1:0]     in_tdata,   // [63:0] message
  input  logic                 in_tlast,   // last_in
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // [62:0] power, [63] zero
  output logic                 out_tlast,  // last_out
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  mx_state_t        state_r, state_nxt;

  logic [VAL_W-1:0] n_r, n_nxt;
  logic [EXP_W-1:0] e_r, e_nxt;
  logic [EXP_W-1:0] e_rem_r, e_rem_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] sq_r, sq_nxt;
  logic             last_r, last_nxt;
  logic             small_n_r, small_n_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  // Handshake and sequencing strobes.
  logic             in_acc;
  logic             cfg_acc;
  logic             slot_free;
  logic             both_idle;
  logic             ld_step;
  logic             ld_out;
  logic             go_on;
  logic [EXP_W-1:0] e_next;
  logic [VAL_W-1:0] acc_new;
  logic [VAL_W-1:0] sq_new;

  // Multiplier operands. Unit A reduces the message first (1 * message mod n)
  // and later forms the conditional product; unit B squares in parallel.
  logic             start_a, start_b;
  logic [VAL_W-1:0] op_a_a, op_b_a;
  logic [MSG_W-1:0] op_a_b, op_b_b;
  logic             busy_a, busy_b;
  logic [VAL_W-1:0] prod_a, prod_b;

  modexp_mulmod u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_a),
    .a       (op_a_a),
    .b       (op_a_b),
    .n       (n_r),
    .busy    (busy_a),
    .product (prod_a)
  );

  modexp_mulmod u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_b),
    .a       (op_b_a),
    .b       (op_b_b),
    .n       (n_r),
    .busy    (busy_b),
    .product (prod_b)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!busy_a) begin
          state_nxt = go_on ? ST_EXP : ST_DONE;
        end
      end
      ST_EXP: begin
        if (both_idle) begin
          state_nxt = go_on ? ST_EXP : ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and strobe logic of the sequencer.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    in_acc    = in_tvalid && in_tready;
    cfg_ready = 1'b1;
    cfg_acc   = cfg_valid && cfg_ready;
    slot_free = !out_valid_r || out_tready;
    both_idle = !busy_a && !busy_b;

    ld_step = 1'b0;
    ld_out  = 1'b0;
    e_next  = e_rem_r;
    acc_new = acc_r;
    sq_new  = sq_r;
    case (state_r)
      ST_REDUCE: begin
        // The reduced message becomes the first square.
        ld_step = !busy_a;
        sq_new  = prod_a;
      end
      ST_EXP: begin
        // One exponent bit retired: keep the product only if the bit was set.
        ld_step = both_idle;
        e_next  = e_rem_r >> 1;
        acc_new = e_rem_r[0] ? prod_a : acc_r;
        sq_new  = prod_b;
      end
      ST_DONE: begin
        ld_out = slot_free;
      end
      default: begin
        ld_step = 1'b0;
      end
    endcase
    go_on = (e_next != '0);

    start_a = in_acc || (ld_step && go_on);
    start_b = ld_step && go_on;
    op_a_a  = in_acc ? VAL_W'(1) : acc_new;
    op_a_b  = in_acc ? (in_tdata & MSG_MASK) : MSG_W'(sq_new);
    op_b_a  = sq_new;
    op_b_b  = MSG_W'(sq_new);
  end

  // Register next values.
  always_comb begin
    n_nxt         = n_r;
    e_nxt         = e_r;
    e_rem_nxt     = e_rem_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    small_n_nxt   = small_n_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (cfg_acc && (cfg_index == CFG_MODULUS)) begin
      n_nxt = cfg_data[VAL_W-1:0];
    end
    if (cfg_acc && (cfg_index == CFG_EXPONENT)) begin
      e_nxt = cfg_data[EXP_W-1:0];
    end

    if (in_acc) begin
      e_rem_nxt   = e_r & EXP_MASK;
      acc_nxt     = VAL_W'(1);
      last_nxt    = in_tlast;
      small_n_nxt = (n_r < VAL_W'(2));
    end else if (ld_step) begin
      e_rem_nxt = e_next;
      acc_nxt   = acc_new;
      sq_nxt    = sq_new;
    end

    // The output register frees the sequencer to take the next word while a
    // finished result still waits downstream.
    if (ld_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = small_n_r ? '0 : acc_r;
      out_last_nxt  = last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= MODULUS_RESET;
      e_r         <= EXPONENT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_rem_r    <= e_rem_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    last_r     <= last_nxt;
    small_n_r  <= small_n_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tlast  = out_last_r;

  // Both partial results stay reduced while exponent bits are being retired.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXP && !small_n_r) |-> (acc_r < n_r))
    else $error("accumulator not reduced below modulus");

  a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXP && !small_n_r) |-> (sq_r < n_r))
    else $error("square not reduced below modulus");

  // No multiplier may still be running when a new word can be taken.
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!busy_a && !busy_b))
    else $error("multiplier busy while sequencer idle");

  // A finished word always lands in the output register.
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && slot_free) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("finished word not moved to output register");

endmodule
